@@ hdl/blip_pkg.sv @@
`default_nettype none
package blip_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int TYPE_COUNT  = 8;
   localparam int ADDR_W      = 4;
   localparam int CNT_W       = 5;
   localparam int TYPE_W      = 3;
   localparam int ID_W        = 48;
   localparam int LVL_W       = 8;
   localparam int WORD_W      = TYPE_W + ID_W + LVL_W;

   // actions
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_MANY = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;
   localparam logic [1:0] ST_FILTER   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_AP_LIMIT    = 2'd0;
   localparam logic [1:0] REG_TOTAL_LIMIT = 2'd1;
   localparam logic [1:0] REG_AP_TYPE     = 2'd2;

   // nibble masks and OUI shift used by the twin test
   localparam logic [7:0] NIB_HI_MASK = 8'hF0;
   localparam logic [7:0] NIB_LO_MASK = 8'h0F;
   localparam int         OUI_SHIFT   = 24;

   // same OUI and at most one differing nibble in the low 24 bits
   function automatic logic twin_ids(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
      logic [23:0] x;
      logic [2:0]  diffs;
      diffs = 3'd0;
      x = a[23:0] ^ b[23:0];
      for (int n = 0; n < 3; n++) begin
         if ((x[8*n +: 8] & NIB_LO_MASK) != 8'd0) diffs = diffs + 3'd1;
         if ((x[8*n +: 8] & NIB_HI_MASK) != 8'd0) diffs = diffs + 3'd1;
      end
      return (a[ID_W-1:OUI_SHIFT] == b[ID_W-1:OUI_SHIFT]) && (diffs <= 3'd1);
   endfunction

endpackage
`default_nettype wire

@@ hdl/blip_ram.sv @@
`default_nettype none
module blip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/beacon_list_insert_and_prune_top.sv @@
`default_nettype none
// Reject, clear and bad action go straight to the result; a read goes through the table RAM.
// An add scans the table for its position and shifts entries to open a gap; a prune then
// runs pair tests over the AP rows or a spread test over interior APs, and moves entries on removal.
// One transaction at a time: the next is taken in the cycle the result shows,
// and the sequential table walk sets the pace.
// The receiver cannot stall: rsp_valid pulses for exactly one cycle.
// Reset clears counts and connected flags and returns the limits to their defaults.
module beacon_list_insert_and_prune_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [1:0]                req_action,
   input  wire logic [3:0]                req_beacon_type,
   input  wire logic [47:0]               req_beacon_id,
   input  wire logic signed [7:0]         req_signal_level,
   input  wire logic                      req_is_connected,
   input  wire logic [3:0]                req_read_position,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [3:0]                     rsp_insert_position,
   output logic                           rsp_removed_valid,
   output logic [3:0]                     rsp_removed_position,
   output logic [4:0]                     rsp_entry_total,
   output logic [4:0]                     rsp_ap_total,
   output logic [2:0]                     rsp_read_type,
   output logic [47:0]                    rsp_read_id,
   output logic signed [7:0]              rsp_read_level,
   output logic                           rsp_read_connected,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [3:0]                csr_data
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_SCAN_RD = 5'd1, S_SCAN_EV = 5'd2,
                          S_SH_RD = 5'd3, S_SH_WR = 5'd4,   S_PUT = 5'd5,
                          S_PJ_RD = 5'd6, S_PJ_EV = 5'd7,   S_PI_RD = 5'd8,
                          S_PI_EV = 5'd9, S_DL_RD = 5'd10,  S_DL_EV = 5'd11,
                          S_DH_RD = 5'd12, S_DH_EV = 5'd13, S_DK_RD = 5'd14,
                          S_DK_EV = 5'd15, S_DK_CMP = 5'd16, S_DR_RD = 5'd17,
                          S_DR_WR = 5'd18, S_RD_RD = 5'd19, S_RD_EV = 5'd20,
                          S_FIN = 5'd21;

   logic [4:0]  state_ff, state_in;
   logic [3:0]  ap_limit_ff, ap_limit_in, total_limit_ff, total_limit_in;
   logic [2:0]  ap_code_ff, ap_code_in;
   logic [4:0]  used_ff, used_in, apc_ff, apc_in;
   logic [blip_pkg::TABLE_DEPTH-1:0] conn_ff, conn_in, conn_up, conn_dn;
   logic [4:0]  idx_ff, idx_in, jdx_ff, jdx_in, first_ff, first_in, last_ff, last_in;
   logic [4:0]  pos_ff, pos_in, victim_ff, victim_in;
   logic        first_set_ff, first_set_in, vfound_ff, vfound_in;
   logic        jap_ff, jap_in, vap_ff, vap_in;
   logic [3:0]  type_ff, type_in;
   logic [47:0] id_ff, id_in, jid_ff, jid_in;
   logic signed [7:0] lvl_ff, lvl_in, low_ff, low_in;
   logic signed [8:0] span_ff, span_in;
   logic signed [14:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [15:0] worst_ff, worst_in;
   logic        cin_ff, cin_in, isap_ff, isap_in;
   logic [3:0]  rp_ff, rp_in;
   logic        valid_ff, valid_in;
   logic [1:0]  stat_ff, stat_in;
   logic [3:0]  insp_ff, insp_in, remp_ff, remp_in;
   logic        remv_ff, remv_in;
   logic [4:0]  etot_ff, etot_in, atot_ff, atot_in;
   logic [2:0]  rtype_ff, rtype_in;
   logic [47:0] rid_ff, rid_in;
   logic signed [7:0] rlvl_ff, rlvl_in;
   logic        rconn_ff, rconn_in;

   logic                               wr_en;
   logic [blip_pkg::ADDR_W-1:0]        wr_addr, rd_addr;
   logic [blip_pkg::WORD_W-1:0]        wr_data, rd_data;
   logic [2:0]                         m_type;
   logic [47:0]                        m_id;
   logic signed [7:0]                  m_lvl;
   logic [3:0]                         quota;
   logic [4:0]                         nonap, apc_new, kpos;
   logic                               is_ap_req, adv, lt;
   logic signed [8:0]                  dlev;
   logic signed [15:0]                 dev;
   logic [15:0]                        dev_abs;

   assign {m_type, m_id, m_lvl} = rd_data;

   blip_ram #(
      .WIDTH(blip_pkg::WORD_W),
      .DEPTH(blip_pkg::TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid            = valid_ff;
   assign rsp_status           = stat_ff;
   assign rsp_insert_position  = insp_ff;
   assign rsp_removed_valid    = remv_ff;
   assign rsp_removed_position = remp_ff;
   assign rsp_entry_total      = etot_ff;
   assign rsp_ap_total         = atot_ff;
   assign rsp_read_type        = rtype_ff;
   assign rsp_read_id          = rid_ff;
   assign rsp_read_level       = rlvl_ff;
   assign rsp_read_connected   = rconn_ff;

   // connected flags moved up or down by one entry
   assign conn_up = {conn_ff[blip_pkg::TABLE_DEPTH-2:0], 1'b0};
   assign conn_dn = {1'b0, conn_ff[blip_pkg::TABLE_DEPTH-1:1]};

   // table RAM addressing per sequencer step
   always_comb begin
      kpos    = first_ff + idx_ff;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      case (state_ff)
         S_SCAN_RD: rd_addr = idx_ff[3:0];
         S_SH_RD:   rd_addr = 4'(idx_ff - 5'd1);
         S_PJ_RD:   rd_addr = jdx_ff[3:0];
         S_PI_RD:   rd_addr = idx_ff[3:0];
         S_DL_RD:   rd_addr = first_ff[3:0];
         S_DH_RD:   rd_addr = last_ff[3:0];
         S_DK_RD:   rd_addr = kpos[3:0];
         S_DK_EV:   rd_addr = kpos[3:0];
         S_DR_RD:   rd_addr = 4'(idx_ff + 5'd1);
         S_RD_RD:   rd_addr = rp_ff;
         S_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[3:0];
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[3:0];
            wr_data = {type_ff[2:0], id_ff, lvl_ff};
         end
         S_DR_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[3:0];
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;  ap_limit_in = ap_limit_ff;  total_limit_in = total_limit_ff;
      ap_code_in = ap_code_ff;  used_in = used_ff;  apc_in = apc_ff;  conn_in = conn_ff;
      idx_in = idx_ff;  jdx_in = jdx_ff;  first_in = first_ff;  last_in = last_ff;
      pos_in = pos_ff;  victim_in = victim_ff;  first_set_in = first_set_ff;
      vfound_in = vfound_ff;  jap_in = jap_ff;  vap_in = vap_ff;
      type_in = type_ff;  id_in = id_ff;  jid_in = jid_ff;
      lvl_in = lvl_ff;  low_in = low_ff;  span_in = span_ff;  p1_in = p1_ff;  p2_in = p2_ff;
      worst_in = worst_ff;  cin_in = cin_ff;  isap_in = isap_ff;  rp_in = rp_ff;
      valid_in = 1'b0;  stat_in = stat_ff;  insp_in = insp_ff;  remp_in = remp_ff;
      remv_in = remv_ff;  etot_in = etot_ff;  atot_in = atot_ff;  rtype_in = rtype_ff;
      rid_in = rid_ff;  rlvl_in = rlvl_ff;  rconn_in = rconn_ff;

      quota     = (total_limit_ff > ap_limit_ff) ? (total_limit_ff - ap_limit_ff) : 4'd0;
      nonap     = used_ff - apc_ff;
      is_ap_req = (req_beacon_type == {1'b0, ap_code_ff});
      lt        = ({1'b0, m_type} < type_ff);
      adv       = lt || (isap_ff && ({1'b0, m_type} == type_ff) && (m_lvl <= lvl_ff));
      apc_new   = apc_ff + {4'd0, isap_ff};
      dlev      = 9'(m_lvl) - 9'(low_ff);
      dev       = 16'(p1_ff) - 16'(p2_ff);
      dev_abs   = dev[15] ? 16'(-dev) : 16'(dev);

      // register writes
      if (csr_valid) begin
         case (csr_index)
            blip_pkg::REG_AP_LIMIT:    ap_limit_in    = csr_data;
            blip_pkg::REG_TOTAL_LIMIT: total_limit_in = csr_data;
            blip_pkg::REG_AP_TYPE:     ap_code_in     = csr_data[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in = req_beacon_type;  id_in = req_beacon_id;
               lvl_in = req_signal_level;  cin_in = req_is_connected;
               isap_in = is_ap_req;  rp_in = req_read_position;
               stat_in = blip_pkg::ST_OK;  insp_in = '0;  remv_in = 1'b0;  remp_in = '0;
               rtype_in = '0;  rid_in = '0;  rlvl_in = '0;  rconn_in = 1'b0;
               state_in = S_FIN;
               case (req_action)
                  blip_pkg::ACT_ADD: begin
                     if (!is_ap_req && nonap >= {1'b0, quota})
                        stat_in = blip_pkg::ST_TOO_MANY;
                     else if (req_beacon_type >= 4'(blip_pkg::TYPE_COUNT))
                        stat_in = blip_pkg::ST_BAD;
                     else if (used_ff >= 5'(blip_pkg::TABLE_DEPTH))
                        stat_in = blip_pkg::ST_TOO_MANY;
                     else begin
                        idx_in = '0;  first_set_in = 1'b0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  blip_pkg::ACT_READ: begin
                     if ({1'b0, req_read_position} < used_ff) state_in = S_RD_RD;
                     else stat_in = blip_pkg::ST_BAD;
                  end
                  blip_pkg::ACT_CLEAR: begin
                     used_in = '0;  apc_in = '0;  conn_in = '0;
                  end
                  default: stat_in = blip_pkg::ST_BAD;
               endcase
            end
         end
         // walk the table for the insert position
         S_SCAN_RD: begin
            if (idx_ff == used_ff) begin
               pos_in = idx_ff;
               if (!first_set_ff) first_in = idx_ff;
               idx_in = used_ff;
               state_in = S_SH_RD;
            end else state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (!lt && !first_set_ff) begin
               first_in = idx_ff;  first_set_in = 1'b1;
            end
            if (adv) begin
               idx_in = idx_ff + 5'd1;  state_in = S_SCAN_RD;
            end else begin
               pos_in = idx_ff;  idx_in = used_ff;  state_in = S_SH_RD;
               if (!first_set_ff && lt) first_in = idx_ff;
            end
         end
         // open a gap at the insert position
         S_SH_RD: state_in = (idx_ff == pos_ff) ? S_PUT : S_SH_WR;
         S_SH_WR: begin
            idx_in = idx_ff - 5'd1;  state_in = S_SH_RD;
         end
         S_PUT: begin
            for (int k = 0; k < blip_pkg::TABLE_DEPTH; k++) begin
               if (k > int'(pos_ff)) conn_in[k] = cin_ff ? 1'b0 : conn_up[k];
               else if (k == int'(pos_ff)) conn_in[k] = cin_ff;
               else conn_in[k] = cin_ff ? 1'b0 : conn_ff[k];
            end
            used_in = used_ff + 5'd1;
            apc_in  = apc_new;
            insp_in = pos_ff[3:0];
            if (isap_ff && apc_new > {1'b0, ap_limit_ff}) begin
               jdx_in  = first_ff;
               last_in = first_ff + apc_new - 5'd1;
               state_in = S_PJ_RD;
            end else state_in = S_FIN;
         end
         // pair search for virtual APs
         S_PJ_RD: state_in = (jdx_ff == last_ff) ? S_DL_RD : S_PJ_EV;
         S_PJ_EV: begin
            jid_in = m_id;  jap_in = (m_type == ap_code_ff);
            idx_in = jdx_ff + 5'd1;  state_in = S_PI_RD;
         end
         S_PI_RD: begin
            if (idx_ff > last_ff) begin
               jdx_in = jdx_ff + 5'd1;  state_in = S_PJ_RD;
            end else state_in = S_PI_EV;
         end
         S_PI_EV: begin
            if (blip_pkg::twin_ids(m_id, jid_ff)) begin
               victim_in = (m_id[23:0] < jid_ff[23:0]) ? jdx_ff : idx_ff;
               vap_in = (m_id[23:0] < jid_ff[23:0]) ? jap_ff : (m_type == ap_code_ff);
               state_in = S_DR_RD;
            end else begin
               idx_in = idx_ff + 5'd1;  state_in = S_PI_RD;
            end
         end
         // spread test over interior APs
         S_DL_RD: state_in = S_DL_EV;
         S_DL_EV: begin
            low_in = m_lvl;  state_in = S_DH_RD;
         end
         S_DH_RD: state_in = S_DH_EV;
         S_DH_EV: begin
            span_in = 9'(m_lvl) - 9'(low_ff);
            idx_in = 5'd1;  worst_in = '0;  vfound_in = 1'b0;
            state_in = S_DK_RD;
         end
         S_DK_RD: begin
            if (idx_ff + 5'd1 >= apc_ff) begin
               if (vfound_ff) begin
                  idx_in = victim_ff;  state_in = S_DR_RD;
               end else begin
                  stat_in = blip_pkg::ST_FILTER;  state_in = S_FIN;
               end
            end else state_in = S_DK_EV;
         end
         S_DK_EV: begin
            p1_in = 15'($signed({1'b0, apc_ff}) * dlev);
            p2_in = 15'($signed({1'b0, idx_ff}) * span_ff);
            state_in = S_DK_CMP;
         end
         S_DK_CMP: begin
            if (dev_abs > worst_ff) begin
               worst_in = dev_abs;  victim_in = kpos;  vfound_in = 1'b1;
               vap_in = (m_type == ap_code_ff);
            end
            idx_in = idx_ff + 5'd1;  state_in = S_DK_RD;
         end
         // close the gap left by the removed entry
         S_DR_RD: begin
            if (idx_ff + 5'd1 >= used_ff) begin
               for (int k = 0; k < blip_pkg::TABLE_DEPTH; k++) begin
                  if (k >= int'(victim_ff)) conn_in[k] = conn_dn[k];
               end
               used_in = used_ff - 5'd1;  apc_in = apc_ff - {4'd0, vap_ff};
               remv_in = 1'b1;  remp_in = victim_ff[3:0];
               state_in = S_FIN;
            end else state_in = S_DR_WR;
         end
         S_DR_WR: begin
            idx_in = idx_ff + 5'd1;  state_in = S_DR_RD;
         end
         S_RD_RD: state_in = S_RD_EV;
         S_RD_EV: begin
            rtype_in = m_type;  rid_in = m_id;  rlvl_in = m_lvl;
            rconn_in = conn_ff[rp_ff];
            state_in = S_FIN;
         end
         S_FIN: begin
            etot_in = used_ff;  atot_in = apc_ff;
            valid_in = 1'b1;  state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // DR_RD entry needs idx at the victim on the pair path too
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;  ap_limit_ff <= 4'd8;  total_limit_ff <= 4'd15;
         ap_code_ff <= 3'd1;  used_ff <= '0;  apc_ff <= '0;  conn_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  ap_limit_ff <= ap_limit_in;
         total_limit_ff <= total_limit_in;  ap_code_ff <= ap_code_in;
         used_ff <= used_in;  apc_ff <= apc_in;  conn_ff <= conn_in;
         valid_ff <= valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      idx_ff <= (state_ff == S_PI_EV && state_in == S_DR_RD) ? victim_in : idx_in;
      jdx_ff <= jdx_in;  first_ff <= first_in;  last_ff <= last_in;  pos_ff <= pos_in;
      victim_ff <= victim_in;  first_set_ff <= first_set_in;  vfound_ff <= vfound_in;
      jap_ff <= jap_in;  vap_ff <= vap_in;
      type_ff <= type_in;  id_ff <= id_in;  jid_ff <= jid_in;  lvl_ff <= lvl_in;
      low_ff <= low_in;  span_ff <= span_in;  p1_ff <= p1_in;  p2_ff <= p2_in;
      worst_ff <= worst_in;  cin_ff <= cin_in;  isap_ff <= isap_in;  rp_ff <= rp_in;
      stat_ff <= stat_in;  insp_ff <= insp_in;  remp_ff <= remp_in;  remv_ff <= remv_in;
      etot_ff <= etot_in;  atot_ff <= atot_in;  rtype_ff <= rtype_in;  rid_ff <= rid_in;
      rlvl_ff <= rlvl_in;  rconn_ff <= rconn_in;
   end
endmodule
`default_nettype wire

@@ hdl/blip_checker.sv @@
`default_nettype none
module blip_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_removed_valid,
   input wire logic [4:0] rsp_entry_total,
   input wire logic [4:0] rsp_ap_total
);
   // a result strobe lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // an accepted transaction makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");

   // AP count never exceeds the entry count, which never exceeds 16
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ap_total <= rsp_entry_total && rsp_entry_total <= 5'd16))
      else $error("inconsistent counts");

   // a removal is reported only with an OK status
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_removed_valid) |-> (rsp_status == blip_pkg::ST_OK))
      else $error("removal reported with error status");
endmodule

bind beacon_list_insert_and_prune_top blip_checker u_blip_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_removed_valid(rsp_removed_valid),
   .rsp_entry_total  (rsp_entry_total),
   .rsp_ap_total     (rsp_ap_total)
);
`default_nettype wire
